// File: design/rsr_pkg.sv
// shared constants, types and control structs of the replacement selection run unit
`default_nettype none
package rsr_pkg;

    localparam int DEF_BUFFER_DEPTH = 16;
    localparam int DEF_KEY_WIDTH    = 32;

    localparam int IN_KEY_W = 32;
    localparam int RUN_W    = 16;

    // run number saturates here
    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    typedef enum logic [1:0] {
        ST_EMPTY  = 2'd0,
        ST_OCC    = 2'd1,
        ST_FROZEN = 2'd2
    } t_entry_st;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN,
        S_SCAN,
        S_TAIL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic fill_wr;
        logic latch;
        logic clear;
        logic open_run;
        logic scan_start;
        logic scan_rd;
        logic commit_normal;
        logic commit_drain;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_phase;
        logic all_frozen;
        logic held_zero;
        logic scan_last;
        logic is_end;
    } t_dp_stat;

endpackage
`default_nettype wire

// File: design/rsr_if.sv
// valid/ready channel interfaces for input keys and emitted run words
`default_nettype none
interface rsr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] key;
    logic        end_of_input;

    modport source (output valid, output key, output end_of_input, input ready);
    modport sink   (input valid, input key, input end_of_input, output ready);
endinterface

interface rsr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_key;
    logic [15:0] run_index;
    logic        run_first;
    logic        last;

    modport source (output valid, output out_key, output run_index, output run_first,
                    output last, input ready);
    modport sink   (input valid, input out_key, input run_index, input run_first,
                    input last, output ready);
endinterface
`default_nettype wire

// File: design/replacement_selection_runs_unit.sv
// Replacement selection run generator for an external sort.
// Input channel i_in carries one word per key (key, end_of_input); output channel
// o_out carries one word per emitted key (out_key, run_index, run_first, last).
// The first BUFFER_DEPTH keys only fill the buffer: each is written to key memory and
// gives no result. After that every key gives one result word with last set.
// A word with end_of_input drains the buffer in run order; its final word has last.
// Each result comes from a serial scan over the key memory, one entry per cycle
// through its single registered read port. The next key is taken no earlier than the
// cycle after the result is taken, so keys do not overlap; each drain word likewise
// comes from its own scan, and a clearing step follows the drain.
// Synchronous reset empties the buffer and starts the run count at zero; key memory
// contents are not cleared. While the receiver stalls the result word holds and no
// new key is accepted; ready on i_in is high only when no key is in progress.
`default_nettype none
module replacement_selection_runs_unit
    import rsr_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int KEY_WIDTH    = DEF_KEY_WIDTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rsr_in_if.sink     i_in,
    rsr_out_if.source  o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;

    rsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_end    (i_in.end_of_input),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid)
    );

    rsr_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .KEY_WIDTH    (KEY_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_key       (i_in.key),
        .i_end       (i_in.end_of_input),
        .o_stat      (w_stat),
        .o_out_key   (o_out.out_key),
        .o_run_index (o_out.run_index),
        .o_run_first (o_out.run_first),
        .o_last      (o_out.last)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // one key in flight: never accepting while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input accepted while a result word is pending");

    // a drain word that is not last keeps the input closed
    a_drain_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> !i_in.ready)
        else $error("input reopened in the middle of a drain");

    // no result can appear in the cycle right after an accepted key
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !o_out.valid)
        else $error("result word appeared before the scan");

    // every result word outside a drain is flagged last
    a_key_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !w_stat.is_end) |-> o_out.last)
        else $error("steady-state result word without last");

endmodule
`default_nettype wire

// File: design/rsr_datapath.sv
// key memory, entry status, counters and serial minimum scan
`default_nettype none
module rsr_datapath
    import rsr_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int KEY_WIDTH    = DEF_KEY_WIDTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic [IN_KEY_W-1:0] i_key,
    input  wire logic                i_end,
    output t_dp_stat                 o_stat,
    output logic [IN_KEY_W-1:0]      o_out_key,
    output logic [RUN_W-1:0]         o_run_index,
    output logic                     o_run_first,
    output logic                     o_last
);

    localparam int IW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [KEY_WIDTH-1:0] r_mem [BUFFER_DEPTH];
    t_entry_st            r_status [BUFFER_DEPTH];

    logic [CW-1:0]        r_fill;
    logic [CW-1:0]        r_held;
    logic [CW-1:0]        r_frozen;
    logic [RUN_W-1:0]     r_run;
    logic                 r_opening;

    logic [KEY_WIDTH-1:0] r_new_key;
    logic                 r_end;

    logic [IW-1:0]        r_cnt;
    logic [KEY_WIDTH-1:0] r_rd_key;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_rd_occ;
    logic                 r_rd_valid;
    logic                 r_found;
    logic [KEY_WIDTH-1:0] r_min_key;
    logic [IW-1:0]        r_min_pos;

    logic                 n_freeze;
    logic                 n_better;

    assign n_freeze = (r_new_key <= r_min_key);
    assign n_better = r_rd_valid && r_rd_occ && (!r_found || (r_rd_key < r_min_key));

    // key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_wr) begin
            r_mem[r_fill[IW-1:0]] <= KEY_WIDTH'(i_key);
        end else if (i_cmd.commit_normal) begin
            r_mem[r_min_pos] <= r_new_key;
        end
        if (i_cmd.scan_rd) begin
            r_rd_key <= r_mem[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                r_status[i] <= ST_EMPTY;
            end
        end else begin
            if (i_cmd.open_run) begin
                for (int i = 0; i < BUFFER_DEPTH; i++) begin
                    if (r_status[i] == ST_FROZEN) begin
                        r_status[i] <= ST_OCC;
                    end
                end
            end
            if (i_cmd.fill_wr) begin
                r_status[r_fill[IW-1:0]] <= ST_OCC;
            end
            if (i_cmd.commit_normal) begin
                r_status[r_min_pos] <= n_freeze ? ST_FROZEN : ST_OCC;
            end
            if (i_cmd.commit_drain) begin
                r_status[r_min_pos] <= ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_fill    <= '0;
            r_held    <= '0;
            r_frozen  <= '0;
            r_run     <= '0;
            r_opening <= 1'b1;
        end else begin
            if (i_cmd.fill_wr) begin
                r_fill <= r_fill + CW'(1);
                r_held <= r_held + CW'(1);
            end
            if (i_cmd.open_run) begin
                if (r_run != RUN_MAX) begin
                    r_run <= r_run + RUN_W'(1);
                end
                r_frozen  <= '0;
                r_opening <= 1'b1;
            end
            if (i_cmd.commit_normal) begin
                r_opening <= 1'b0;
                if (n_freeze) begin
                    r_frozen <= r_frozen + CW'(1);
                end
            end
            if (i_cmd.commit_drain) begin
                r_opening <= 1'b0;
                r_held    <= r_held - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_new_key <= KEY_WIDTH'(i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end <= 1'b0;
        end else if (i_cmd.latch) begin
            r_end <= i_end;
        end
    end

    // serial scan: read one entry per cycle, compare it the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_rd_valid <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.scan_rd;
            if (i_cmd.scan_start) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_rd) begin
                r_cnt <= r_cnt + IW'(1);
            end
            if (n_better) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_idx <= r_cnt;
            r_rd_occ <= (r_status[r_cnt] == ST_OCC);
        end
        if (n_better) begin
            r_min_key <= r_rd_key;
            r_min_pos <= r_rd_idx;
        end
    end

    assign o_stat.fill_phase = (r_fill < CW'(BUFFER_DEPTH));
    assign o_stat.all_frozen = (r_held == r_frozen);
    assign o_stat.held_zero  = (r_held == '0);
    assign o_stat.scan_last  = (r_cnt == IW'(BUFFER_DEPTH - 1));
    assign o_stat.is_end     = r_end;

    assign o_out_key   = IN_KEY_W'(r_min_key);
    assign o_run_index = r_run;
    assign o_run_first = r_opening;
    // in a drain the word that empties the buffer is the last one
    assign o_last      = r_end ? (r_held == CW'(1)) : 1'b1;

endmodule
`default_nettype wire

// File: design/rsr_ctrl.sv
// sequencer for fill, run opening, minimum scan and result handoff
`default_nettype none
module rsr_ctrl
    import rsr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_end,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_in_ready,
    output logic          o_out_valid
);

    t_state r_state;
    t_state n_state;
    logic   n_accept;

    assign n_accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (n_accept && (i_in_end || !i_stat.fill_phase)) begin
                    n_state = S_OPEN;
                end
            end
            S_OPEN: begin
                if (i_stat.is_end && i_stat.held_zero) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_state = i_stat.is_end ? S_OPEN : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.latch   = n_accept;
                o_cmd.fill_wr = n_accept && !i_in_end && i_stat.fill_phase;
            end
            S_OPEN: begin
                if (i_stat.is_end && i_stat.held_zero) begin
                    o_cmd.clear = 1'b1;
                end else begin
                    o_cmd.open_run   = i_stat.all_frozen;
                    o_cmd.scan_start = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            S_TAIL: begin
                o_cmd = '0;
            end
            S_EMIT: begin
                o_out_valid         = 1'b1;
                o_cmd.commit_normal = i_out_ready && !i_stat.is_end;
                o_cmd.commit_drain  = i_out_ready && i_stat.is_end;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire
